>>> hdl/cbpll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbpll_pkg;

	localparam int CH_W       = 7;
	localparam int KHZ_W      = 16;
	localparam int HZ_W       = 26;
	localparam int WORD_W     = 32;
	localparam int CAL_W      = 7;
	localparam int PLAN_W     = 4;
	localparam int BAND_W     = 4;
	localparam int REF_W      = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// serial divider: dividend is the carrier or carrier plus IF, divisor is twice the reference
	localparam int DIVD_W = HZ_W + 1;
	localparam int DIVS_W = REF_W + 1;
	localparam int DCNT_W = $clog2(DIVD_W);

	typedef logic [PLAN_W-1:0] plan_t;

	localparam plan_t PLAN_EU = 4'd0;
	localparam plan_t PLAN_CE = 4'd1;
	localparam plan_t PLAN_UK = 4'd2;
	localparam plan_t PLAN_PL = 4'd3;
	localparam plan_t PLAN_I0 = 4'd4;
	localparam plan_t PLAN_I2 = 4'd5;
	localparam plan_t PLAN_DE = 4'd6;
	localparam plan_t PLAN_IN = 4'd7;
	localparam plan_t PLAN_RU = 4'd8;
	localparam plan_t PLAN_PC = 4'd9;
	localparam plan_t PLAN_PX = 4'd10;
	localparam plan_t PLAN_AU = 4'd11;
	localparam plan_t PLAN_NL = 4'd12;
	localparam plan_t PLAN_AM = 4'd13;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_REGION_PLAN  = 3'd0;
	localparam cfg_idx_t CFG_BAND_INDEX   = 3'd1;
	localparam cfg_idx_t CFG_REFERENCE_HZ = 3'd2;
	localparam cfg_idx_t CFG_RX_OFFSET_HZ = 3'd3;
	localparam cfg_idx_t CFG_WORD_BASE    = 3'd4;

	localparam logic [REF_W-1:0] REF_HZ_RESET    = 20'd5000;
	localparam logic [HZ_W-1:0]  RX_OFFSET_RESET = 26'd10695000;
	localparam logic [CAL_W-1:0] CAL_UK          = 7'd120;
	localparam logic [9:0]       KHZ_TO_HZ       = 10'd1000;

	typedef struct packed {
		logic             hit;
		logic [KHZ_W-1:0] khz;
	} lookup_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam logic [KHZ_W-1:0] GROUP_STEP [4] = '{16'd0, 16'd10, 16'd20, 16'd40};

	localparam logic [KHZ_W-1:0] PC_TABLE [50] = '{
		16'd25645, 16'd25695, 16'd25745, 16'd25795, 16'd25845,
		16'd26095, 16'd26145, 16'd26195, 16'd26245, 16'd26295,
		16'd26545, 16'd26595, 16'd26645, 16'd26695, 16'd26745,
		16'd26995, 16'd27045, 16'd27095, 16'd27145, 16'd27195,
		16'd27445, 16'd27495, 16'd27545, 16'd27595, 16'd27645,
		16'd27895, 16'd27945, 16'd27995, 16'd28045, 16'd28095,
		16'd28345, 16'd28395, 16'd28445, 16'd28495, 16'd28545,
		16'd28795, 16'd28845, 16'd28895, 16'd28945, 16'd28995,
		16'd29245, 16'd29295, 16'd29345, 16'd29395, 16'd29445,
		16'd29695, 16'd29745, 16'd29795, 16'd29845, 16'd29895
	};

	localparam logic [KHZ_W-1:0] AM_TABLE [10] = '{
		16'd27680, 16'd27720, 16'd27820, 16'd27860, 16'd27880,
		16'd27900, 16'd27910, 16'd27940, 16'd27960, 16'd27980
	};

endpackage
`default_nettype wire

>>> hdl/cbpll_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cbpll_chan_if;
	import cbpll_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] channel_number;

	modport source (output valid, output channel_number, input ready);
	modport sink (input valid, input channel_number, output ready);
endinterface
`default_nettype wire

>>> hdl/cbpll_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cbpll_result_if;
	import cbpll_pkg::*;

	logic              valid;
	logic              ready;
	logic [HZ_W-1:0]   carrier_hz;
	logic [WORD_W-1:0] transmit_word;
	logic [WORD_W-1:0] receive_word;
	logic [CAL_W-1:0]  calibration_value;
	logic              channel_not_in_plan;

	modport source (output valid, output carrier_hz, output transmit_word,
		output receive_word, output calibration_value, output channel_not_in_plan,
		input ready);
	modport sink (input valid, input carrier_hz, input transmit_word,
		input receive_word, input calibration_value, input channel_not_in_plan,
		output ready);
endinterface
`default_nettype wire

>>> hdl/cbpll_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cbpll_cfg_if;
	import cbpll_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/cb_channel_to_pll_divider.sv
// CB channel to synthesizer divider words.
// chan (valid/ready) carries a channel number. The block maps it through the
// configured channel plan to a carrier in kHz, scales it to Hz, and divides
// carrier and carrier plus IF by twice the reference to form the transmit and
// receive words (word_base added). result carries one item per request.
// cfg is a write port that is always ready: index 0 plan, 1 band, 2 reference
// in Hz, 3 IF offset in Hz, 4 word base; other indexes are ignored. Write it
// only while the block is idle.
// Timing: a request is taken only in the idle state. The result is loaded into
// the output register from the final state, and the next request can be taken
// once the block is back in idle, so items do not overlap. Both passes run
// through the shared 27-step restoring divider.
// An unlisted channel reuses the last carrier and flags channel_not_in_plan.
// Reset clears the configuration to its defaults and the last carrier to 0.
// A stalled result is held in the output register; a finished item waits in
// its last state until that register frees, while the block still takes the
// next request once it is back in idle.
`timescale 1ns / 1ps
`default_nettype none
module cb_channel_to_pll_divider (
	input  logic           clk,
	input  logic           arst_n,
	cbpll_chan_if.sink     chan,
	cbpll_result_if.source result,
	cbpll_cfg_if.sink      cfg
);
	import cbpll_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_LOOK = 8'b0000_0010,
		ST_MUL  = 8'b0000_0100,
		ST_TXGO = 8'b0000_1000,
		ST_TXW  = 8'b0001_0000,
		ST_RXGO = 8'b0010_0000,
		ST_RXW  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t             state_q;
	plan_t              plan_q;
	logic [BAND_W-1:0]  band_q;
	logic [REF_W-1:0]   ref_q;
	logic [HZ_W-1:0]    offset_q;
	logic [WORD_W-1:0]  base_q;
	logic [KHZ_W-1:0]   khz_q;
	logic [CH_W-1:0]    ch_q;
	logic               miss_q;
	logic [HZ_W-1:0]    f_q;
	logic [DIVD_W-1:0]  txq_q;
	logic               out_valid_q;
	logic [HZ_W-1:0]    carrier_q;
	logic [WORD_W-1:0]  tx_word_q;
	logic [WORD_W-1:0]  rx_word_q;
	logic [CAL_W-1:0]   cal_q;
	logic               nip_q;

	lookup_t            lk;
	logic [REF_W-1:0]   ref_eff;
	logic [DIVS_W-1:0]  div_den;
	logic [DIVD_W-1:0]  div_num;
	logic [DIVD_W-1:0]  div_quot;
	logic               div_start;
	div_stat_t          div_stat;
	logic               load_out;

	cbpll_plan_lookup u_lookup (
		.region_plan    (plan_q),
		.band_index     (band_q),
		.channel_number (ch_q),
		.result         (lk)
	);

	// zero reference counts as one
	assign ref_eff   = (ref_q == '0) ? REF_W'(1) : ref_q;
	assign div_den   = {ref_eff, 1'b0};
	assign div_start = (state_q == ST_TXGO) || (state_q == ST_RXGO);
	assign div_num   = (state_q == ST_TXGO) ? {1'b0, f_q}
	                                        : DIVD_W'(f_q) + DIVD_W'(offset_q);

	cbpll_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	assign cfg.ready  = 1'b1;
	assign chan.ready = (state_q == ST_IDLE);
	assign load_out   = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_q   <= PLAN_EU;
			band_q   <= '0;
			ref_q    <= REF_HZ_RESET;
			offset_q <= RX_OFFSET_RESET;
			base_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_REGION_PLAN:  plan_q   <= cfg.data[PLAN_W-1:0];
				CFG_BAND_INDEX:   band_q   <= cfg.data[BAND_W-1:0];
				CFG_REFERENCE_HZ: ref_q    <= cfg.data[REF_W-1:0];
				CFG_RX_OFFSET_HZ: offset_q <= cfg.data[HZ_W-1:0];
				CFG_WORD_BASE:    base_q   <= cfg.data[WORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			khz_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (chan.valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					// unlisted channel: hold the last carrier
					if (lk.hit) begin
						khz_q <= lk.khz;
					end
					state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_TXGO;
				ST_TXGO: state_q <= ST_TXW;
				ST_TXW: begin
					if (div_stat.done) begin
						state_q <= ST_RXGO;
					end
				end
				ST_RXGO: state_q <= ST_RXW;
				ST_RXW: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (chan.valid && chan.ready) begin
			ch_q <= chan.channel_number;
		end
		if (state_q == ST_LOOK) begin
			miss_q <= !lk.hit;
		end
		if (state_q == ST_MUL) begin
			f_q <= HZ_W'(khz_q) * HZ_W'(KHZ_TO_HZ);
		end
		if (state_q == ST_TXW && div_stat.done) begin
			txq_q <= div_quot;
		end
		if (load_out) begin
			carrier_q <= f_q;
			tx_word_q <= base_q + WORD_W'(txq_q);
			rx_word_q <= base_q + WORD_W'(div_quot);
			cal_q     <= (plan_q == PLAN_UK) ? CAL_UK : '0;
			nip_q     <= miss_q;
		end
	end

	assign result.valid               = out_valid_q;
	assign result.carrier_hz          = carrier_q;
	assign result.transmit_word       = tx_word_q;
	assign result.receive_word        = rx_word_q;
	assign result.calibration_value   = cal_q;
	assign result.channel_not_in_plan = nip_q;

`ifndef ASSERT_OFF
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final state");

	a_carrier_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (result.carrier_hz == $past(f_q)))
		else $error("carrier does not match scaled kHz value");

	a_wait_needs_div: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_TXW) || (state_q == ST_RXW)) |-> (div_stat.busy || div_stat.done))
		else $error("waiting on an idle divider");
`endif
endmodule
`default_nettype wire

>>> hdl/cbpll_plan_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
module cbpll_plan_lookup (
	input  cbpll_pkg::plan_t                    region_plan,
	input  logic [cbpll_pkg::BAND_W-1:0]        band_index,
	input  logic [cbpll_pkg::CH_W-1:0]          channel_number,
	output cbpll_pkg::lookup_t                  result
);
	import cbpll_pkg::*;

	logic [KHZ_W-1:0] band_khz;
	logic [CH_W-1:0]  ch_m1;

	// EU-like shape: 4-step groups, specials 23..25, then 10 kHz steps up to top
	function automatic lookup_t std_plan(
		input logic [CH_W-1:0]  ch,
		input logic [KHZ_W-1:0] base,
		input logic [KHZ_W-1:0] s23,
		input logic [KHZ_W-1:0] s24,
		input logic [KHZ_W-1:0] s25,
		input logic [KHZ_W-1:0] lin,
		input logic [CH_W-1:0]  top
	);
		lookup_t         r;
		logic [CH_W-1:0] k;
		logic [CH_W-1:0] d;
		k = ch - 7'd1;
		d = ch - 7'd26;
		r.hit = 1'b1;
		r.khz = '0;
		priority if (ch == 7'd0) begin
			r.hit = 1'b0;
		end else if (ch <= 7'd22) begin
			r.khz = base + KHZ_W'(k[CH_W-1:2]) * 16'd50 + GROUP_STEP[k[1:0]];
		end else if (ch == 7'd23) begin
			r.khz = s23;
		end else if (ch == 7'd24) begin
			r.khz = s24;
		end else if (ch == 7'd25) begin
			r.khz = s25;
		end else if (ch <= top) begin
			r.khz = lin + KHZ_W'(d) * 16'd10;
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

	assign band_khz = KHZ_W'(band_index) * 16'd450;
	assign ch_m1    = channel_number - 7'd1;

	always_comb begin
		result = '0;
		unique case (region_plan)
			PLAN_EU, PLAN_CE, PLAN_AU: begin
				result = std_plan(channel_number, 16'd26965, 16'd27255, 16'd27235,
					16'd27245, 16'd27265, 7'd127);
			end
			PLAN_UK: begin
				result.hit = 1'b1;
				result.khz = 16'd27591 + KHZ_W'(channel_number) * 16'd10;
			end
			PLAN_PL: begin
				result = std_plan(channel_number, 16'd26960, 16'd27250, 16'd27230,
					16'd27240, 16'd27260, 7'd127);
			end
			PLAN_I0: begin
				result = std_plan(channel_number, 16'd26965, 16'd27255, 16'd27235,
					16'd27245, 16'd27265, 7'd40);
			end
			PLAN_I2: begin
				// I2 changes its specials for 24 and 25 and adds a run below channel 1 from 26 to 36
				if (channel_number >= 7'd26 && channel_number <= 7'd34) begin
					result.hit = 1'b1;
					result.khz = 16'd26865 + KHZ_W'(channel_number - 7'd25) * 16'd10;
				end else if (channel_number == 7'd35) begin
					result.hit = 1'b1;
					result.khz = 16'd26855;
				end else if (channel_number == 7'd36) begin
					result.hit = 1'b1;
					result.khz = 16'd26865;
				end else begin
					result = std_plan(channel_number, 16'd26965, 16'd27255, 16'd27245,
						16'd27265, 16'd27265, 7'd25);
				end
			end
			PLAN_DE: begin
				if (channel_number >= 7'd41) begin
					result.hit = 1'b1;
					result.khz = 16'd26565 + KHZ_W'(channel_number - 7'd41) * 16'd10;
				end else begin
					result = std_plan(channel_number, 16'd26965, 16'd27255, 16'd27235,
						16'd27245, 16'd27265, 7'd40);
				end
			end
			PLAN_IN: begin
				result = std_plan(channel_number, 16'd26965, 16'd27255, 16'd27235,
					16'd27245, 16'd27265, 7'd27);
			end
			PLAN_RU: begin
				result = std_plan(channel_number, 16'd25615 + band_khz,
					16'd25905 + band_khz, 16'd25885 + band_khz,
					16'd25895 + band_khz, 16'd25915 + band_khz, 7'd127);
			end
			PLAN_PC: begin
				if (channel_number >= 7'd1 && channel_number <= 7'd50) begin
					result.hit = 1'b1;
					result.khz = PC_TABLE[ch_m1[5:0]];
				end
			end
			PLAN_PX: begin
				result = std_plan(channel_number, 16'd25610 + band_khz,
					16'd25900 + band_khz, 16'd25880 + band_khz,
					16'd25890 + band_khz, 16'd25910 + band_khz, 7'd127);
			end
			PLAN_NL: begin
				result = std_plan(channel_number, 16'd26330, 16'd26620, 16'd26600,
					16'd26610, 16'd26630, 7'd127);
			end
			PLAN_AM: begin
				if (channel_number >= 7'd1 && channel_number <= 7'd10) begin
					result.hit = 1'b1;
					result.khz = AM_TABLE[ch_m1[3:0]];
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end
endmodule
`default_nettype wire

>>> hdl/cbpll_serial_div.sv
`timescale 1ns / 1ps
`default_nettype none
module cbpll_serial_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [cbpll_pkg::DIVD_W-1:0]       dividend,
	input  logic [cbpll_pkg::DIVS_W-1:0]       divisor,
	output logic [cbpll_pkg::DIVD_W-1:0]       quotient,
	output cbpll_pkg::div_stat_t               stat
);
	import cbpll_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] num_q;
	logic [DIVS_W-1:0] den_q;
	logic [DIVS_W:0]   trial;
	logic [DIVS_W:0]   diff;
	logic              fits;

	// restoring step: one quotient bit per cycle while busy, shifted into the dividend register
	assign trial = {rem_q, num_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCNT_W'(DIVD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			num_q <= {num_q[DIVD_W-2:0], fits};
		end
	end

	assign quotient  = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire
